[design/assert_macros.svh]
// Assertion macros used by the checker file.
// No dependencies.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
// Implication check under active-low reset.
`define CHK_IMPLY(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("check failed");
// Next-cycle implication check under active-low reset.
`define CHK_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("check failed");
`endif

[design/tce_pkg.sv]
// Package for the toy CPU execute unit: opcodes, widths, command and status types.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none
package tce_pkg;
    localparam int DATA_WORDS = 256;
    localparam int MEM_AW = $clog2(DATA_WORDS);
    localparam int MEM_BASE = 16384;
    localparam int IN_W = 48;
    localparam int OUT_W = 80;

    typedef enum logic [3:0] {
        OP_NONE = 4'd0, OP_MOVE = 4'd1, OP_ADD = 4'd2, OP_SUB = 4'd3, OP_MUL = 4'd4,
        OP_DIV = 4'd5, OP_AND = 4'd6, OP_OR = 4'd7, OP_NOT = 4'd8, OP_CMP = 4'd9,
        OP_JUMP = 4'd10, OP_IN = 4'd11, OP_OUT = 4'd12, OP_LOCK = 4'd13,
        OP_UNLOCK = 4'd14, OP_SLEEP = 4'd15
    } t_op;

    localparam logic [1:0] ACT_NONE = 2'd0;
    localparam logic [1:0] ACT_LOCK = 2'd1;
    localparam logic [1:0] ACT_UNLOCK = 2'd2;
    localparam logic [1:0] ACT_SLEEP = 2'd3;

    // controller -> datapath
    typedef struct packed {
        logic load;       // capture instruction word
        logic rd_a;       // issue memory read for destination
        logic rd_b;       // issue memory read for source
        logic lat_a;      // latch memory data as a
        logic lat_b;      // latch memory data as b
        logic div_start;
        logic div_step;
        logic commit;     // write back and build result
    } t_cmd;

    // datapath -> controller
    typedef struct packed {
        logic need_a;     // destination operand lives in memory
        logic need_b;     // source operand lives in memory
        logic is_div;
        logic div_last;
    } t_sts;
endpackage
`default_nettype wire

[design/tce_ram.sv]
// Generic single-port RAM with registered read.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none
module tce_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 256
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_addr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    output logic      [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    always_ff @(posedge i_clk) begin
        if (i_we) r_mem[i_addr] <= i_wdata;
        o_rdata <= r_mem[i_addr];
    end
endmodule
`default_nettype wire

[design/tce_ctrl.sv]
// Controller FSM of the execute unit: sequences memory clear, fetch, divide, commit.
// Depends on tce_pkg.
`timescale 1ns / 1ps
`default_nettype none
module tce_ctrl import tce_pkg::*; (
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    input  wire logic i_in_valid,
    output logic      o_in_ready,
    output logic      o_out_load,
    input  wire logic i_out_free,
    output logic      o_clr_busy,
    input  wire t_sts i_sts,
    output t_cmd      o_cmd
);
    typedef enum logic [9:0] {
        S_IDLE  = 10'b0000000001, S_DEC   = 10'b0000000010,
        S_RDA   = 10'b0000000100, S_WA    = 10'b0000001000,
        S_RDB   = 10'b0000010000, S_WB    = 10'b0000100000,
        S_DSTRT = 10'b0001000000, S_DIV   = 10'b0010000000,
        S_COMM  = 10'b0100000000, S_CLEAR = 10'b1000000000
    } t_state;
    t_state r_state, n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_state <= S_CLEAR;
        else r_state <= n_state;
    end

    // next state and command decode
    always_comb begin
        n_state = r_state;
        o_cmd = '0;
        o_in_ready = 1'b0;
        o_out_load = 1'b0;
        o_clr_busy = 1'b0;
        unique case (r_state)
            S_CLEAR: begin
                o_clr_busy = 1'b1;
                if (i_sts.div_last) n_state = S_IDLE;
            end
            S_IDLE: begin
                o_in_ready = 1'b1;
                o_cmd.load = i_in_valid;
                if (i_in_valid) n_state = S_DEC;
            end
            S_DEC: n_state = i_sts.need_a ? S_RDA : (i_sts.need_b ? S_RDB : S_DSTRT);
            S_RDA: begin
                o_cmd.rd_a = 1'b1;
                n_state = S_WA;
            end
            S_WA: begin
                o_cmd.lat_a = 1'b1;
                n_state = i_sts.need_b ? S_RDB : S_DSTRT;
            end
            S_RDB: begin
                o_cmd.rd_b = 1'b1;
                n_state = S_WB;
            end
            S_WB: begin
                o_cmd.lat_b = 1'b1;
                n_state = S_DSTRT;
            end
            S_DSTRT: begin
                o_cmd.div_start = 1'b1;
                n_state = i_sts.is_div ? S_DIV : S_COMM;
            end
            S_DIV: begin
                o_cmd.div_step = 1'b1;
                if (i_sts.div_last) n_state = S_COMM;
            end
            S_COMM: begin
                if (i_out_free) begin
                    o_cmd.commit = 1'b1;
                    o_out_load = 1'b1;
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end
endmodule
`default_nettype wire

[design/tce_dpath.sv]
// Datapath of the execute unit: register file, data memory, ALU, serial divider.
// Depends on tce_pkg and tce_ram.
`timescale 1ns / 1ps
`default_nettype none
module tce_dpath import tce_pkg::*; (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire t_cmd              i_cmd,
    input  wire logic              i_clr_busy,
    output t_sts                   o_sts,
    input  wire logic [IN_W-1:0]   i_word,
    output logic      [OUT_W-1:0]  o_result
);
    // architectural state
    logic [15:0] r_regs [8];
    logic [15:0] r_ip;
    logic [11:0] r_ir;
    logic [1:0]  r_flag;
    // captured instruction
    logic [3:0]  r_mode;
    logic [7:0]  r_sel;
    logic [15:0] r_imm, r_inv;
    logic [15:0] r_a, r_b;
    // memory addresses latched at decode
    logic [MEM_AW-1:0] r_addr_a, r_addr_b;
    // divider
    logic [15:0] r_quo, r_rem, r_dvs;
    logic [4:0]  r_cnt;
    logic [MEM_AW-1:0] r_clr_addr;

    logic [3:0] w_d, w_s;
    logic       w_dv, w_sv, w_err;
    logic [15:0] w_mem_rd;
    logic        w_we;
    logic [MEM_AW-1:0] w_addr;
    logic [15:0] w_wdata;
    logic [15:0] w_reg_d, w_reg_s;

    assign w_d  = r_sel[7:4];
    assign w_s  = r_sel[3:0];
    assign w_dv = (w_d >= 4'd1) && (w_d <= 4'd8);
    assign w_sv = (w_s <= 4'd8);

    // register file reads for the two operand nibbles
    assign w_reg_d = r_regs[3'(w_d - 4'd1)];
    assign w_reg_s = r_regs[3'(w_s - 4'd1)];

    // word index of an address register: ((r-16384)/2) mod depth, truncating division
    function automatic logic [MEM_AW-1:0] f_index(input logic [15:0] v);
        logic signed [17:0] t;
        logic signed [17:0] q;
        t = $signed({{2{v[15]}}, v}) - 18'sd16384;
        q = (t + ((t < 0) ? 18'sd1 : 18'sd0)) >>> 1;
        return q[MEM_AW-1:0];
    endfunction

    // memory operand flags (not with s in 1..8 reads memory at reg s, even below 5)
    logic w_not_mem;
    assign w_not_mem = (r_mode == OP_NOT) && (w_s != 4'd0);
    logic w_alu;
    assign w_alu = (r_mode >= OP_MOVE && r_mode <= OP_OR) || r_mode == OP_CMP;
    always_comb begin
        o_sts.need_a = ((w_alu && !(r_mode == OP_MOVE && w_s == 4'd0)) || r_mode == OP_OUT)
                       && w_dv && w_sv && w_d >= 4'd5;
        if (r_mode == OP_OUT) o_sts.need_a = w_dv && w_d >= 4'd5;
        o_sts.need_b = ((w_alu && w_dv && w_sv && w_s >= 4'd5)
                        || (w_not_mem && w_sv));
        o_sts.is_div = (r_mode == OP_DIV) && w_dv && w_sv && r_b != 16'd0;
        o_sts.div_last = i_clr_busy ? (r_clr_addr == MEM_AW'(DATA_WORDS - 1))
                                    : (r_cnt == 5'd15);
    end

    // decode cycle is the one after load
    logic r_dec;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_dec <= 1'b0;
        else r_dec <= i_cmd.load;
    end

    // operand a/b: register or immediate values at decode, memory data when latched
    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_mode <= i_word[3:0];
            r_sel  <= i_word[11:4];
            r_imm  <= i_word[27:12];
            r_inv  <= i_word[43:28];
        end
        if (r_dec) begin
            r_a <= (w_d >= 4'd1 && w_d <= 4'd8) ? w_reg_d : 16'd0;
            r_b <= (w_s == 4'd0) ? r_imm : w_reg_s;
            r_addr_a <= f_index(w_reg_d);
            r_addr_b <= f_index(w_reg_s);
        end
        if (i_cmd.lat_a) r_a <= w_mem_rd;
        if (i_cmd.lat_b) r_b <= w_mem_rd;
    end

    // restoring divider on magnitudes, one quotient bit a cycle
    logic [15:0] w_ma, w_mb;
    logic [16:0] w_trial;
    assign w_ma = r_a[15] ? 16'(-r_a) : r_a;
    assign w_mb = r_b[15] ? 16'(-r_b) : r_b;
    assign w_trial = {r_rem, r_quo[15]} - {1'b0, r_dvs};
    always_ff @(posedge i_clk) begin
        if (i_cmd.div_start) begin
            r_quo <= w_ma;
            r_rem <= 16'd0;
            r_dvs <= w_mb;
            r_cnt <= 5'd0;
        end else if (i_cmd.div_step) begin
            r_cnt <= r_cnt + 5'd1;
            if (!w_trial[16]) begin
                r_rem <= w_trial[15:0];
                r_quo <= {r_quo[14:0], 1'b1};
            end else begin
                r_rem <= {r_rem[14:0], r_quo[15]};
                r_quo <= {r_quo[14:0], 1'b0};
            end
        end
    end

    // execute result
    logic [15:0] w_res, w_prod;
    logic        w_wr, w_wmem, w_take;
    logic [2:0]  w_rk;
    logic [MEM_AW-1:0] w_waddr;
    logic [1:0]  w_nflag;
    logic [15:0] w_nip, w_ov, w_arg;
    logic [13:0] w_jc;
    logic        w_oval;
    logic [1:0]  w_act;
    logic signed [15:0] w_jq;
    assign w_prod = 16'(r_a * r_b);
    assign w_jq = $signed(r_imm) / 16'sd4;
    always_comb begin
        w_res = 16'd0; w_wr = 1'b0; w_wmem = 1'b0; w_err = 1'b0;
        w_rk = 3'(w_d - 4'd1); w_waddr = r_addr_a;
        w_nflag = r_flag; w_nip = r_ip + 16'd4; w_jc = 14'd0;
        w_oval = 1'b0; w_ov = 16'd0; w_act = ACT_NONE; w_arg = 16'd0;
        w_take = 1'b0;
        unique case (r_mode)
            OP_MOVE, OP_ADD, OP_SUB, OP_MUL, OP_DIV, OP_AND, OP_OR, OP_CMP: begin
                if (!w_dv || !w_sv) w_err = 1'b1;
                else begin
                    w_wr = 1'b1;
                    w_wmem = (w_d >= 4'd5) && !(r_mode == OP_MOVE && w_s == 4'd0);
                    unique case (r_mode)
                        OP_MOVE: w_res = r_b;
                        OP_ADD:  w_res = r_a + r_b;
                        OP_SUB:  w_res = r_a - r_b;
                        OP_MUL:  w_res = w_prod;
                        OP_DIV: begin
                            if (r_b == 16'd0) begin
                                w_err = 1'b1; w_wr = 1'b0;
                            end else begin
                                w_res = (r_a[15] ^ r_b[15]) ? 16'(-r_quo) : r_quo;
                            end
                        end
                        OP_AND:  w_res = {15'd0, (r_a != 0) && (r_b != 0)};
                        OP_OR:   w_res = {15'd0, (r_a != 0) || (r_b != 0)};
                        default: begin
                            w_wr = 1'b0;
                            w_nflag = ($signed(r_a) > $signed(r_b)) ? 2'b01 :
                                      (($signed(r_a) < $signed(r_b)) ? 2'b11 : 2'b00);
                        end
                    endcase
                end
            end
            OP_NOT: begin
                if (w_s == 4'd0) begin
                    if (!w_dv) w_err = 1'b1;
                    else begin
                        w_wr = 1'b1;
                        w_res = {15'd0, w_reg_d == 16'd0};
                    end
                end else if (!w_sv) w_err = 1'b1;
                else begin
                    w_wr = 1'b1; w_wmem = 1'b1; w_waddr = r_addr_b;
                    w_res = {15'd0, r_b == 16'd0};
                end
            end
            OP_JUMP: begin
                w_take = (r_sel == 8'd0) || (r_sel == 8'd1 && r_flag == 2'b00)
                      || (r_sel == 8'd2 && r_flag == 2'b01)
                      || (r_sel == 8'd3 && r_flag == 2'b11);
                if (w_take) begin
                    w_nip = r_ip + r_imm;
                    w_jc = 14'(w_jq);
                end
            end
            OP_IN: begin
                if (!w_dv) w_err = 1'b1;
                else begin
                    w_wr = 1'b1; w_wmem = w_d >= 4'd5; w_res = r_inv;
                end
            end
            OP_OUT: begin
                if (!w_dv) w_err = 1'b1;
                else begin
                    w_oval = 1'b1; w_ov = r_a;
                end
            end
            OP_LOCK:   w_act = ACT_LOCK;
            OP_UNLOCK: w_act = ACT_UNLOCK;
            OP_SLEEP: begin
                w_act = ACT_SLEEP; w_arg = r_imm;
            end
            default: w_err = 1'b1;
        endcase
        if (w_err) begin
            w_wr = 1'b0; w_nip = r_ip; w_jc = 14'd0; w_oval = 1'b0; w_ov = 16'd0;
            w_act = ACT_NONE; w_arg = 16'd0; w_nflag = r_flag;
        end
    end

    // memory port: clear sweep, commit write, or operand read
    assign w_we = i_clr_busy || (i_cmd.commit && w_wr && w_wmem);
    assign w_wdata = i_clr_busy ? 16'd0 : w_res;
    assign w_addr = i_clr_busy ? r_clr_addr :
                    (i_cmd.commit ? w_waddr : (i_cmd.rd_b ? r_addr_b : r_addr_a));
    tce_ram #(.WIDTH(16), .DEPTH(DATA_WORDS)) u_mem (
        .i_clk(i_clk), .i_we(w_we), .i_addr(w_addr), .i_wdata(w_wdata), .o_rdata(w_mem_rd)
    );

    // state update
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < 8; i++) r_regs[i] <= 16'd0;
            r_ip <= 16'd0; r_ir <= 12'd0; r_flag <= 2'b00;
            r_clr_addr <= '0;
        end else begin
            if (i_clr_busy) r_clr_addr <= r_clr_addr + 1'b1;
            if (i_cmd.commit) begin
                if (w_wr && !w_wmem) r_regs[w_rk] <= w_res;
                if (!w_err) begin
                    r_ip <= w_nip;
                    r_ir <= {r_mode, r_sel};
                    r_flag <= w_nflag;
                end
            end
        end
    end

    logic [11:0] w_ir_out;
    logic [1:0]  w_flag_out;
    assign w_ir_out = w_err ? r_ir : {r_mode, r_sel};
    assign w_flag_out = w_nflag;
    // fields high to low
    assign o_result = {w_err, w_arg, w_act, w_ov, w_oval, w_jc, w_flag_out,
                       w_ir_out, w_nip};
endmodule
`default_nettype wire

[design/toy_cpu_execute_unit.sv]
// Top level of the toy CPU execute unit: controller, datapath and output register.
// Depends on tce_pkg, tce_ctrl, tce_dpath.
`timescale 1ns / 1ps
`default_nettype none
// One instruction word in, one result word out. After reset the unit zeroes
// the DATA_WORDS (256) words of data memory before it takes a word.
// An instruction passes accept, decode, start and commit when its
// operands are registers or the immediate, plus a read and a latch step per
// memory operand (registered RAM read), and a divide adds the steps of the
// one-bit-a-cycle divider. The result sits in an output register, so the
// next word is taken while it waits.
module toy_cpu_execute_unit import tce_pkg::*; (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              s_axis_tvalid,
    output logic                   s_axis_tready,
    // mode[3:0], operand_sel[11:4], immediate[27:12], input_value[43:28]
    input  wire logic [IN_W-1:0]   s_axis_tdata,
    output logic                   m_axis_tvalid,
    input  wire logic              m_axis_tready,
    // next_ip[15:0], instr_reg[27:16], cmp_flag[29:28], jump_count[43:30],
    // out_valid[44], out_value[60:45], host_action[62:61], action_arg[78:63],
    // exec_error[79]
    output logic      [OUT_W-1:0]  m_axis_tdata
);
    t_cmd w_cmd;
    t_sts w_sts;
    logic w_load, w_clr;
    logic [OUT_W-1:0] w_res;
    logic r_valid;

    tce_ctrl u_ctrl (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_in_valid(s_axis_tvalid),
        .o_in_ready(s_axis_tready), .o_out_load(w_load),
        .i_out_free(!r_valid || m_axis_tready), .o_clr_busy(w_clr),
        .i_sts(w_sts), .o_cmd(w_cmd)
    );
    tce_dpath u_dpath (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_cmd(w_cmd), .i_clr_busy(w_clr),
        .o_sts(w_sts), .i_word(s_axis_tdata), .o_result(w_res)
    );

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_valid <= 1'b0;
        else if (w_load) r_valid <= 1'b1;
        else if (m_axis_tready) r_valid <= 1'b0;
    end
    logic [OUT_W-1:0] r_data;
    always_ff @(posedge i_clk) begin
        if (w_load) r_data <= w_res;
    end
    assign m_axis_tvalid = r_valid;
    assign m_axis_tdata = r_data;
endmodule
`default_nettype wire

[design/tce_checker.sv]
// Port-level checker for the execute unit, bound to the top level.
// Depends on tce_pkg and assert_macros.svh.
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"
module tce_checker import tce_pkg::*; (
    input wire logic             i_clk,
    input wire logic             i_rst_n,
    input wire logic             s_axis_tvalid,
    input wire logic             s_axis_tready,
    input wire logic             m_axis_tvalid,
    input wire logic             m_axis_tready,
    input wire logic [OUT_W-1:0] m_axis_tdata
);
    // a stalled result word holds
    `CHK_NEXT(a_hold, i_clk, i_rst_n, m_axis_tvalid && !m_axis_tready, $stable(m_axis_tdata))
    // an accepted word is not followed by another accept next cycle
    `CHK_NEXT(a_seq, i_clk, i_rst_n, s_axis_tvalid && s_axis_tready, !s_axis_tready)
    // rejected instructions carry no side effects
    `CHK_IMPLY(a_err, i_clk, i_rst_n, m_axis_tvalid && m_axis_tdata[79],
               m_axis_tdata[62:61] == ACT_NONE && !m_axis_tdata[44])
endmodule
bind toy_cpu_execute_unit tce_checker u_chk (
    .i_clk(i_clk), .i_rst_n(i_rst_n), .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready), .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready), .m_axis_tdata(m_axis_tdata)
);
`default_nettype wire
